[hdl/bwt_pkg.sv]
// shared types and constants for the blocked waiter table
package bwt_pkg;

  localparam int KEY_W  = 32;
  localparam int PROC_W = 8;
  localparam int ENTRY_W = KEY_W + PROC_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_CHECK,
    ST_SH_RD,
    ST_SH_WR,
    ST_RESULT
  } state_t;

endpackage

[hdl/bwt_ram.sv]
// generic single write port ram with registered read
module bwt_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[hdl/blocked_waiter_table.sv]
// blocked waiter table: ordered key/process table with oldest-match removal
// insert: the entry is written at the tail as the request is taken, then the result state
// loads the output register; remove: search and check test each entry, oldest first,
//   then shift read and shift write move each younger entry down a slot; one ram read per entry
// one request at a time; a held output register keeps the next result waiting
// rst_n clears the fill count, sequencer and output valid; table contents stay undefined
module blocked_waiter_table #(
  parameter int TABLE_ENTRIES = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_kind,
  input  logic [bwt_pkg::KEY_W-1:0] in_sem_addr,
  input  logic [bwt_pkg::PROC_W-1:0] in_proc_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_ok,
  output logic [bwt_pkg::PROC_W-1:0] out_proc_out
);

  // index width, count width (holds the depth) and compare width
  localparam int IW = $clog2(TABLE_ENTRIES);
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int SW = CW + 1;

  bwt_pkg::state_t state_r, state_nxt;

  logic [CW-1:0]              count_r, count_nxt;
  logic [IW-1:0]              idx_r, idx_nxt;
  logic [bwt_pkg::KEY_W-1:0]  key_r, key_nxt;
  logic                       res_ok_r, res_ok_nxt;
  logic [bwt_pkg::PROC_W-1:0] res_proc_r, res_proc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_ok_r, out_ok_nxt;
  logic [bwt_pkg::PROC_W-1:0] out_proc_r, out_proc_nxt;

  // ram port controls
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [bwt_pkg::ENTRY_W-1:0] wr_data;
  logic [IW-1:0]               rd_addr;
  logic [bwt_pkg::ENTRY_W-1:0] rd_data;

  logic                        in_take;
  logic                        table_full;
  logic                        key_match;
  logic                        more_after;
  logic                        out_free;
  logic [SW-1:0]               idx_inc;

  // entry word is {key, owner}
  bwt_ram #(
    .WIDTH(bwt_pkg::ENTRY_W),
    .DEPTH(TABLE_ENTRIES)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_take    = in_valid && in_ready;
  assign table_full = (count_r == CW'(TABLE_ENTRIES));
  assign key_match  = (rd_data[bwt_pkg::ENTRY_W-1 -: bwt_pkg::KEY_W] == key_r);
  assign idx_inc    = SW'(idx_r) + SW'(1);
  // in check this tests for a younger entry; after the decrement it tests for one more move
  assign more_after = (idx_inc < SW'(count_r));
  assign out_free   = !out_valid_r || out_ready;

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      bwt_pkg::ST_IDLE: begin
        if (in_take) begin
          if (in_kind == bwt_pkg::KIND_REMOVE && count_r != '0) begin
            state_nxt = bwt_pkg::ST_SEARCH;
          end else begin
            state_nxt = bwt_pkg::ST_RESULT;
          end
        end
      end
      bwt_pkg::ST_SEARCH: state_nxt = bwt_pkg::ST_CHECK;
      bwt_pkg::ST_CHECK: begin
        if (key_match && more_after) begin
          state_nxt = bwt_pkg::ST_SH_RD;
        end else if (!key_match && more_after) begin
          state_nxt = bwt_pkg::ST_SEARCH;
        end else begin
          state_nxt = bwt_pkg::ST_RESULT;
        end
      end
      bwt_pkg::ST_SH_RD: state_nxt = bwt_pkg::ST_SH_WR;
      bwt_pkg::ST_SH_WR: begin
        if (more_after) begin
          state_nxt = bwt_pkg::ST_SH_RD;
        end else begin
          state_nxt = bwt_pkg::ST_RESULT;
        end
      end
      bwt_pkg::ST_RESULT: begin
        if (out_free) begin
          state_nxt = bwt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bwt_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and ram port
  always_comb begin
    in_ready = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = idx_r;
    wr_data  = rd_data;
    rd_addr  = idx_r;
    unique case (state_r)
      bwt_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // append at the tail straight away
        wr_en    = in_valid && (in_kind == bwt_pkg::KIND_INSERT) && !table_full;
        wr_addr  = count_r[IW-1:0];
        wr_data  = {in_sem_addr, in_proc_id};
      end
      bwt_pkg::ST_SH_RD: begin
        // fetch the next younger entry
        rd_addr = idx_inc[IW-1:0];
      end
      bwt_pkg::ST_SH_WR: begin
        // move it down one slot to close the gap
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // datapath registers
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    key_nxt       = key_r;
    res_ok_nxt    = res_ok_r;
    res_proc_nxt  = res_proc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ok_nxt    = out_ok_r;
    out_proc_nxt  = out_proc_r;
    unique case (state_r)
      bwt_pkg::ST_IDLE: begin
        idx_nxt      = '0;
        key_nxt      = in_sem_addr;
        res_ok_nxt   = 1'b0;
        res_proc_nxt = '0;
        if (in_take && in_kind == bwt_pkg::KIND_INSERT && !table_full) begin
          count_nxt  = count_r + CW'(1);
          res_ok_nxt = 1'b1;
        end
      end
      bwt_pkg::ST_CHECK: begin
        if (key_match) begin
          // oldest match found: report its owner and drop it from the count
          res_ok_nxt   = 1'b1;
          res_proc_nxt = rd_data[bwt_pkg::PROC_W-1:0];
          count_nxt    = count_r - CW'(1);
        end else if (more_after) begin
          idx_nxt = idx_inc[IW-1:0];
        end
      end
      bwt_pkg::ST_SH_WR: begin
        idx_nxt = idx_inc[IW-1:0];
      end
      bwt_pkg::ST_RESULT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_proc_nxt  = res_proc_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bwt_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    key_r      <= key_nxt;
    res_ok_r   <= res_ok_nxt;
    res_proc_r <= res_proc_nxt;
    out_ok_r   <= out_ok_nxt;
    out_proc_r <= out_proc_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_ok       = out_ok_r;
  assign out_proc_out = out_proc_r;

endmodule

[sim/blocked_waiter_table_tb.sv]
// self-checking testbench for the blocked waiter table
module blocked_waiter_table_tb;

  // table depth handed to the block, and the predictor's capacity
  localparam int TABLE_DEPTH = 32;
  // cycles with no handshake on either side before the run is declared hung;
  // the worst honest gap is the long output hold plus one full-table search
  localparam int QUIET_LIMIT = 4000;
  // length of the long output hold that fills the block and stalls its input
  localparam int LONG_HOLD = 300;
  // settling time after the last reply, a little over one full-table search
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [bwt_pkg::KEY_W-1:0]  key;
    logic [bwt_pkg::PROC_W-1:0] owner;
  } waiter_t;

  typedef struct packed {
    logic                       ok;
    logic [bwt_pkg::PROC_W-1:0] owner;
  } reply_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic                       in_kind;
  logic [bwt_pkg::KEY_W-1:0]  in_sem_addr;
  logic [bwt_pkg::PROC_W-1:0] in_proc_id;
  logic                       out_valid;
  logic                       out_ready;
  logic                       out_ok;
  logic [bwt_pkg::PROC_W-1:0] out_proc_out;

  // predictor copy of the table, oldest waiter at the front
  waiter_t waiting_list[$];
  // replies owed by the block, oldest first
  reply_t  awaited_replies[$];
  // a few addresses reused often so that removes find matches and duplicates pile up
  logic [bwt_pkg::KEY_W-1:0] hot_addrs[8];

  int mismatch_count;
  int inserts_stored;
  int full_rejects;
  int remove_hits;
  int remove_misses;
  int quiet_cycles;

  // idling on both sides is switched off for the closing stretch
  bit idle_enabled;
  // raised by the backpressure test; the receiver process then counts its own hold
  bit long_hold_ask;
  int hold_left;
  int stall_left;

  blocked_waiter_table #(
    .TABLE_ENTRIES(TABLE_DEPTH)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_sem_addr (in_sem_addr),
    .in_proc_id  (in_proc_id),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_ok      (out_ok),
    .out_proc_out(out_proc_out)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // applies one request to the predictor table and returns the reply it owes
  function automatic reply_t apply_waiter_op(input logic kind,
                                             input logic [bwt_pkg::KEY_W-1:0] key,
                                             input logic [bwt_pkg::PROC_W-1:0] pid);
    reply_t  r;
    waiter_t w;
    int      hit;
    r   = '0;
    hit = -1;
    if (kind == bwt_pkg::KIND_INSERT) begin
      // the table full case leaves everything as it was
      if (waiting_list.size() < TABLE_DEPTH) begin
        w.key   = key;
        w.owner = pid;
        waiting_list.push_back(w);
        r.ok = 1'b1;
        inserts_stored++;
      end else begin
        full_rejects++;
      end
    end else begin
      // oldest match wins; younger entries close up behind it
      for (int i = 0; i < waiting_list.size() && hit < 0; i++) begin
        if (waiting_list[i].key == key) hit = i;
      end
      if (hit >= 0) begin
        r.ok    = 1'b1;
        r.owner = waiting_list[hit].owner;
        waiting_list.delete(hit);
        remove_hits++;
      end else begin
        remove_misses++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] %s", $realtime, msg);
    mismatch_count++;
  endtask

  // random process id
  function automatic logic [bwt_pkg::PROC_W-1:0] rand_pid();
    logic [31:0] v;
    v = $urandom;
    return v[bwt_pkg::PROC_W-1:0];
  endfunction

  // one of the hot addresses at random
  function automatic logic [bwt_pkg::KEY_W-1:0] hot_addr();
    logic [31:0] v;
    v = $urandom;
    return hot_addrs[v[2:0]];
  endfunction

  // offers one request and holds it until taken; valid stays high on return so a
  // following request can go out back to back
  task automatic post_request(input logic kind, input logic [bwt_pkg::KEY_W-1:0] key,
                              input logic [bwt_pkg::PROC_W-1:0] pid);
    int gap;
    if (idle_enabled && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_sem_addr <= key;
    in_proc_id  <= pid;
    do @(posedge clk); while (!in_ready);
    awaited_replies.push_back(apply_waiter_op(kind, key, pid));
  endtask

  // address for a random remove: mostly one that is waiting now, so searches hit
  function automatic logic [bwt_pkg::KEY_W-1:0] pick_remove_addr();
    if (waiting_list.size() != 0 && $urandom_range(0, 9) < 7)
      return waiting_list[$urandom_range(0, waiting_list.size() - 1)].key;
    if ($urandom_range(0, 3) != 0) return hot_addr();
    return $urandom;
  endfunction

  // address for a random insert: hot addresses breed duplicates
  function automatic logic [bwt_pkg::KEY_W-1:0] pick_insert_addr();
    if ($urandom_range(0, 4) != 0) return hot_addr();
    return $urandom;
  endfunction

  // empty table, zero id, extreme addresses, duplicates, oldest and middle removal
  task automatic test_directed_cases();
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_0000, 8'hFF);  // remove from an empty table
    post_request(bwt_pkg::KIND_INSERT, 32'h0000_0000, 8'h00);  // id zero must still read as found
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_0000, 8'hA5);
    post_request(bwt_pkg::KIND_INSERT, 32'hFFFF_FFFF, 8'hFF);
    post_request(bwt_pkg::KIND_REMOVE, 32'hFFFF_FFFE, 8'h00);  // near miss on the top address
    post_request(bwt_pkg::KIND_REMOVE, 32'hFFFF_FFFF, 8'h00);
    // duplicates: removes come back oldest first, then run dry
    post_request(bwt_pkg::KIND_INSERT, 32'h0000_1000, 8'h01);
    post_request(bwt_pkg::KIND_INSERT, 32'h0000_1000, 8'h02);
    post_request(bwt_pkg::KIND_INSERT, 32'h8000_0000, 8'h03);
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_1000, 8'h00);
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_1000, 8'h00);
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_1000, 8'h00);
    post_request(bwt_pkg::KIND_REMOVE, 32'h8000_0000, 8'h00);
    // oldest entry unlinked, then a middle one, then tail, then the one left
    post_request(bwt_pkg::KIND_INSERT, 32'h0000_2000, 8'h04);
    post_request(bwt_pkg::KIND_INSERT, 32'h0000_3000, 8'h05);
    post_request(bwt_pkg::KIND_INSERT, 32'h0000_4000, 8'h06);
    post_request(bwt_pkg::KIND_INSERT, 32'h0000_5000, 8'h80);
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_2000, 8'h00);
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_4000, 8'h00);  // gap in the middle
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_5000, 8'h00);
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_3000, 8'h00);
    post_request(bwt_pkg::KIND_REMOVE, 32'h0000_3000, 8'h00);
  endtask

  // fill to capacity, push a few past it, miss on a full table, then drain from random places
  task automatic test_fill_to_capacity();
    logic [bwt_pkg::KEY_W-1:0] key;
    while (waiting_list.size() < TABLE_DEPTH)
      post_request(bwt_pkg::KIND_INSERT, pick_insert_addr(), rand_pid());
    repeat (4) post_request(bwt_pkg::KIND_INSERT, $urandom, rand_pid());
    // a full-depth miss walks every entry
    post_request(bwt_pkg::KIND_REMOVE, 32'h1234_5679, 8'h00);
    while (waiting_list.size() != 0) begin
      key = waiting_list[$urandom_range(0, waiting_list.size() - 1)].key;
      post_request(bwt_pkg::KIND_REMOVE, key, rand_pid());
    end
  endtask

  // receiver holds off for a long stretch while requests keep coming
  task automatic test_output_backpressure();
    long_hold_ask = 1'b1;
    repeat (12) begin
      if ($urandom_range(0, 1) == 0)
        post_request(bwt_pkg::KIND_INSERT, pick_insert_addr(), rand_pid());
      else
        post_request(bwt_pkg::KIND_REMOVE, pick_remove_addr(), rand_pid());
    end
  endtask

  // mixed traffic in spells that lean towards filling or towards draining,
  // so the table sweeps between empty and full
  task automatic test_random_traffic(input int count);
    int fill_bias;
    fill_bias = 50;
    for (int n = 0; n < count; n++) begin
      if (n % 40 == 0) fill_bias = $urandom_range(0, 1) ? 75 : 30;
      if ($urandom_range(0, 99) < fill_bias)
        post_request(bwt_pkg::KIND_INSERT, pick_insert_addr(), rand_pid());
      else
        post_request(bwt_pkg::KIND_REMOVE, pick_remove_addr(), rand_pid());
    end
  endtask

  // reply checker and output ready driver
  always @(posedge clk) begin
    reply_t want;
    if (out_valid && out_ready) begin
      if (awaited_replies.size() == 0) begin
        report_mismatch($sformatf("reply with no request outstanding: ok=%0d id=%0d",
                                  out_ok, out_proc_out));
      end else begin
        want = awaited_replies.pop_front();
        if (out_ok !== want.ok)
          report_mismatch($sformatf("reply mismatch on ok: got %0d, expected %0d",
                                    out_ok, want.ok));
        if (out_proc_out !== want.owner)
          report_mismatch($sformatf("reply mismatch on proc_out: got %0d, expected %0d",
                                    out_proc_out, want.owner));
      end
    end
    if (long_hold_ask) begin
      long_hold_ask = 1'b0;
      hold_left = LONG_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 16) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles", $realtime, QUIET_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_kind     <= bwt_pkg::KIND_INSERT;
    in_sem_addr <= '0;
    in_proc_id  <= '0;
    out_ready   <= 1'b0;
    quiet_cycles <= 0;
    mismatch_count = 0;
    inserts_stored = 0;
    full_rejects   = 0;
    remove_hits    = 0;
    remove_misses  = 0;
    hold_left      = 0;
    stall_left     = 0;
    long_hold_ask  = 1'b0;
    idle_enabled   = 1'b1;
    hot_addrs[0] = 32'h0000_0000;
    hot_addrs[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) hot_addrs[i] = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_fill_to_capacity();
    test_output_backpressure();
    test_random_traffic(820);
    test_fill_to_capacity();
    // closing stretch at full rate on both sides
    idle_enabled = 1'b0;
    test_random_traffic(120);

    @(posedge clk);
    in_valid <= 1'b0;
    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d stored inserts, %0d rejected on a full table,",
             inserts_stored, full_rejects);
    $display("%0d removes that found a waiter and %0d that found none",
             remove_hits, remove_misses);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
